@@ rtl/fvc_pkg.sv @@
// Shared constants and types for the six-plane frustum volume cull block.
// No dependencies; imported by every module of the block.
`default_nettype none

package fvc_pkg;

   localparam int PLANE_COUNT     = 6;
   localparam int CORNER_COUNT    = 8;
   localparam int AXIS_COUNT      = 3;
   localparam int REG_BITS        = 64;
   localparam int CSR_INDEX_BITS  = $clog2(PLANE_COUNT);
   localparam int COORD_BITS_DEF  = 16;
   localparam int NORMAL_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CMD_BITS        = 3;
   localparam int RSP_DATA_BITS   = 8;

   localparam logic [CMD_BITS-1:0] CMD_BOX      = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_CYLINDER = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_SPHERE   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE     = 3'd3;

   typedef enum logic [CMD_BITS-1:0] {
      KIND_BOX      = 3'd0,
      KIND_CYLINDER = 3'd1,
      KIND_SPHERE   = 3'd2,
      KIND_NONE     = 3'd3,
      KIND_UNKNOWN  = 3'd4
   } kind_type;

endpackage

`default_nettype wire

@@ rtl/fvc_front.sv @@
// Front end of the frustum cull: takes requests, classifies the volume kind.
// Depends on fvc_pkg; feeds fvc_queue.
`default_nettype none

module fvc_front import fvc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [6*COORD_BITS-4:0]       req_data,
   input  wire logic [CMD_BITS-1:0]           req_tuser,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output logic [CMD_BITS+6*COORD_BITS-4:0]   push_data
);

   logic                          hold_valid_ff, hold_valid_in;
   kind_type                      kind_ff, kind_in;
   logic [6*COORD_BITS-4:0]       data_ff;

   assign req_tready = !hold_valid_ff || push_ready;
   assign push_valid = hold_valid_ff;
   assign push_data  = {kind_ff, data_ff};

   always_comb begin
      unique case (req_tuser)
         CMD_BOX:      kind_in = KIND_BOX;
         CMD_CYLINDER: kind_in = KIND_CYLINDER;
         CMD_SPHERE:   kind_in = KIND_SPHERE;
         CMD_NONE:     kind_in = KIND_NONE;
         default:      kind_in = KIND_UNKNOWN;
      endcase
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_tready) begin
         hold_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         kind_ff <= kind_in;
         data_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fvc_queue.sv @@
// Short first-in first-out queue between the front and back of the cull block.
// Depends on fvc_pkg for its depth.
`default_nettype none

module fvc_queue import fvc_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != (PTR_BITS+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fvc_back.sv @@
// Back end of the frustum cull: plane distance pipeline and visibility decision.
// Depends on fvc_pkg; takes items from fvc_queue and drives the response channel.
`default_nettype none

module fvc_back import fvc_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [PLANE_COUNT-1:0][REG_BITS-1:0]  planes,
   input  wire logic                                  item_valid,
   output logic                                       item_ready,
   input  wire logic [CMD_BITS+6*COORD_BITS-4:0]      item_data,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [RSP_DATA_BITS-1:0]                   rsp_tdata
);

   localparam int C     = COORD_BITS;
   localparam int N     = NORMAL_BITS;
   localparam int NFRAC = N - 2;
   localparam int PW    = C + N;
   localparam int DW    = PW + 4;
   localparam int RW    = REG_BITS + C + 3 * N;

   logic                 adv;
   logic [RW-1:0]        wide      [PLANE_COUNT];
   logic signed [N-1:0]  nrm       [PLANE_COUNT][AXIS_COUNT];
   logic signed [C-1:0]  ofs       [PLANE_COUNT];
   logic signed [C-1:0]  crd       [AXIS_COUNT];
   logic signed [C-1:0]  ext_s     [AXIS_COUNT];
   kind_type             item_kind;

   // Stage A: products.
   logic                 a_valid_ff;
   kind_type             a_kind_ff;
   logic [C-2:0]         a_ext_ff;
   logic signed [PW-1:0] bprod_in  [PLANE_COUNT][AXIS_COUNT];
   logic signed [PW-1:0] bprod_ff  [PLANE_COUNT][AXIS_COUNT];
   logic signed [PW-1:0] eprod_in  [PLANE_COUNT][AXIS_COUNT];
   logic signed [PW-1:0] eprod_ff  [PLANE_COUNT][AXIS_COUNT];

   // Stage B: base distances.
   logic                 b_valid_ff;
   kind_type             b_kind_ff;
   logic [C-2:0]         b_ext_ff;
   logic signed [DW-1:0] base_in   [PLANE_COUNT];
   logic signed [DW-1:0] base_ff   [PLANE_COUNT];
   logic signed [PW-1:0] b_eprod_ff [PLANE_COUNT][AXIS_COUNT];

   // Stage C: per-corner and round tests.
   logic                 c_valid_ff;
   kind_type             c_kind_ff;
   logic [CORNER_COUNT-1:0] corner_in, corner_ff;
   logic                 round_in, round_ff;

   // Stage D: response register.
   logic                 rsp_valid_ff;
   logic                 vis_in, vis_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign item_ready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS-1)'(0), vis_ff};

   assign crd[0]    = item_data[C-1:0];
   assign crd[1]    = item_data[2*C-1:C];
   assign crd[2]    = item_data[3*C-1:2*C];
   assign ext_s[0]  = {1'b0, item_data[4*C-2:3*C]};
   assign ext_s[1]  = {1'b0, item_data[5*C-3:4*C-1]};
   assign ext_s[2]  = {1'b0, item_data[6*C-4:5*C-2]};
   assign item_kind = kind_type'(item_data[CMD_BITS+6*C-4:6*C-3]);

   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         wide[p]   = RW'(planes[p]);
         ofs[p]    = wide[p][C-1:0];
         nrm[p][2] = wide[p][C+N-1:C];
         nrm[p][1] = wide[p][C+2*N-1:C+N];
         nrm[p][0] = wide[p][C+3*N-1:C+2*N];
      end
   end

   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         for (int k = 0; k < AXIS_COUNT; k++) begin
            bprod_in[p][k] = PW'(nrm[p][k]) * PW'(crd[k]);
            eprod_in[p][k] = PW'(nrm[p][k]) * PW'(ext_s[k]);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         base_in[p] = DW'(bprod_ff[p][0]) + DW'(bprod_ff[p][1]) + DW'(bprod_ff[p][2])
                      + (DW'(ofs[p]) <<< NFRAC);
      end
   end

   always_comb begin
      logic signed [DW-1:0] sum;
      logic signed [DW-1:0] thr;
      logic signed [DW-1:0] lhs;
      sum = '0;
      thr = DW'(b_ext_ff) <<< NFRAC;
      lhs = '0;
      round_in = 1'b1;
      for (int c = 0; c < CORNER_COUNT; c++) begin
         corner_in[c] = 1'b1;
         for (int p = 0; p < PLANE_COUNT; p++) begin
            sum = base_ff[p];
            if ((c & 1) != 0) begin
               sum = sum + DW'(b_eprod_ff[p][0]);
            end
            if ((c & 2) != 0) begin
               sum = sum + DW'(b_eprod_ff[p][1]);
            end
            if ((c & 4) != 0) begin
               sum = sum + DW'(b_eprod_ff[p][2]);
            end
            if (sum <= 0) begin
               corner_in[c] = 1'b0;
            end
         end
      end
      for (int p = 0; p < PLANE_COUNT; p++) begin
         if (b_kind_ff == KIND_SPHERE) begin
            lhs = (base_ff[p] <<< 1) + thr;
         end else begin
            lhs = base_ff[p] + thr;
         end
         if (lhs <= 0) begin
            round_in = 1'b0;
         end
      end
   end

   always_comb begin
      unique case (c_kind_ff)
         KIND_BOX:      vis_in = |corner_ff;
         KIND_CYLINDER: vis_in = round_ff;
         KIND_SPHERE:   vis_in = round_ff;
         KIND_NONE:     vis_in = 1'b0;
         default:       vis_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= item_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_kind_ff  <= item_kind;
         a_ext_ff   <= item_data[4*C-2:3*C];
         bprod_ff   <= bprod_in;
         eprod_ff   <= eprod_in;
         b_kind_ff  <= a_kind_ff;
         b_ext_ff   <= a_ext_ff;
         base_ff    <= base_in;
         b_eprod_ff <= eprod_ff;
         c_kind_ff  <= b_kind_ff;
         corner_ff  <= corner_in;
         round_ff   <= round_in;
         vis_ff     <= vis_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/frustum_volume_cull.sv @@
// Top level of the six-plane frustum volume cull block: plane registers,
// front end, queue and back end. Depends on fvc_pkg, fvc_front, fvc_queue, fvc_back.
//
// Usage: each request on the req_ channel carries one bounding volume (kind in
// req_tuser, position and extents in req_tdata); each produces exactly one
// response on the rsp_ channel whose bit 0 says whether the volume is visible.
// Responses come back in request order.
// The six planes are written through the csr_ port (index 0 right, 1 left,
// 2 bottom, 3 top, 4 far, 5 near); writes to other indexes are dropped. Write
// the planes only while no request is in flight.
// Throughput is one request per cycle while the receiver does not stall. A request
// passes through the front register and the queue, then the multiply, sum and
// plane-test stages of the back end before it reaches the response register.
// When the receiver stalls, the back pipeline holds and the four-entry queue
// and front register keep taking requests until they fill.
// Reset clears all planes to zero and empties the pipeline.
`default_nettype none

module frustum_volume_cull import fvc_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int NORMAL_BITS = NORMAL_BITS_DEF,
   localparam int TDATA_BITS = ((6 * COORD_BITS - 3 + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: coord_x, coord_y, coord_z, extent_x, extent_y, extent_z.
   input  wire logic [TDATA_BITS-1:0]      req_tdata,
   // Fields from bit 0: command.
   input  wire logic [CMD_BITS-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // Fields from bit 0: visible.
   output logic [RSP_DATA_BITS-1:0]        rsp_tdata,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [REG_BITS-1:0]        csr_wdata
);

   localparam int ITEM_BITS = CMD_BITS + 6 * COORD_BITS - 3;

   logic [PLANE_COUNT-1:0][REG_BITS-1:0] planes_ff;
   logic                 push_valid, push_ready;
   logic [ITEM_BITS-1:0] push_data;
   logic                 pop_valid, pop_ready;
   logic [ITEM_BITS-1:0] pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else if (csr_we && csr_index < CSR_INDEX_BITS'(PLANE_COUNT)) begin
         planes_ff[csr_index] <= csr_wdata;
      end
   end

   fvc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata[6*COORD_BITS-4:0]),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fvc_queue #(
      .WIDTH (ITEM_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fvc_back #(
      .COORD_BITS  (COORD_BITS),
      .NORMAL_BITS (NORMAL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .planes     (planes_ff),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item_data  (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
